// ----- rtl/core/skcs_pkg.sv -----
package skcs_pkg;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 16;
   localparam int QUEUE_DEPTH = 2;

   // one classified key, handed from the divider to the segmenter
   typedef struct packed {
      logic [WORD_W-1:0] column;
      logic [POS_W-1:0]  position;
      logic              final_key;
   } item_type;

   // one result word
   typedef struct packed {
      logic [WORD_W-1:0] column_start;
      logic [WORD_W-1:0] column_length;
      logic              set_closed;
      logic [WORD_W-1:0] set_first_column;
      logic [WORD_W-1:0] set_column_count;
      logic              last_record;
   } result_type;

endpackage

// ----- rtl/core/sorted_key_column_segmenter.sv -----
// Sorted key column segmenter. Feed ascending block keys on req_, one word per
// key, with req_final_key set on the last key of a list. Each key is split by
// the axis length (csr_axis_length, zero acts as one) into a column number and
// a position; a run of consecutive positions in one column closes as a column
// result on rsp_, and a change of column number also closes the set, whose
// first column and column count ride on the same result word. The final key
// flushes the open column and set with rsp_last_record high and restarts the
// list at zero. The front is a one-bit-per-cycle restoring divider; the next
// key is taken as the quotient leaves. A two-word queue decouples the divider
// from the segmenter, which retires one queued word per cycle while its result
// slot is free; a word that both closes a column and ends the list holds the
// queue until its flush word is out. Only the low KEY_WIDTH bits of a key are
// used. No start-up sweep is needed after reset. Write csr_ only while idle.
module sorted_key_column_segmenter #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [skcs_pkg::WORD_W-1:0] req_sorted_key,
   input  logic                        req_final_key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [skcs_pkg::WORD_W-1:0] rsp_column_start,
   output logic [skcs_pkg::WORD_W-1:0] rsp_column_length,
   output logic                        rsp_set_closed,
   output logic [skcs_pkg::WORD_W-1:0] rsp_set_first_column,
   output logic [skcs_pkg::WORD_W-1:0] rsp_set_column_count,
   output logic                        rsp_last_record,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [skcs_pkg::POS_W-1:0]  csr_axis_length
);
   import skcs_pkg::*;

   // keys are at most one word wide, so clamp the divider length to that
   localparam int KEY_W = (KEY_WIDTH < WORD_W) ? KEY_WIDTH : WORD_W;

   logic [POS_W-1:0] axis_ff, axis_in;
   logic [POS_W-1:0] divisor;
   logic             div_valid, div_ready;
   item_type         div_item;
   logic             back_valid, back_ready;
   item_type         back_item;
   result_type       result;

   // configuration register: always ready, take the word on handshake
   assign csr_ready = 1'b1;
   assign axis_in   = (csr_valid && csr_ready) ? csr_axis_length : axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= POS_W'(1);
      end else begin
         axis_ff <= axis_in;
      end
   end

   // a zero axis length divides as one
   assign divisor = (axis_ff == '0) ? POS_W'(1) : axis_ff;

   // front: split each key into column and position
   skcs_divider #(
      .KEY_W (KEY_W)
   ) u_divider (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sorted_key (req_sorted_key),
      .req_final_key  (req_final_key),
      .divisor        (divisor),
      .q_valid        (div_valid),
      .q_ready        (div_ready),
      .q_data         (div_item)
   );

   // hold classified keys so either side may stall on its own
   skcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_item)
   );

   // back: compare with the previous key, close columns and sets
   skcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (back_valid),
      .q_ready   (back_ready),
      .q_data    (back_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (result)
   );

   assign rsp_column_start     = result.column_start;
   assign rsp_column_length    = result.column_length;
   assign rsp_set_closed       = result.set_closed;
   assign rsp_set_first_column = result.set_first_column;
   assign rsp_set_column_count = result.set_column_count;
   assign rsp_last_record      = result.last_record;

endmodule

// ----- rtl/core/skcs_divider.sv -----
module skcs_divider #(
   parameter int KEY_W = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [skcs_pkg::WORD_W-1:0] req_sorted_key,
   input  logic                        req_final_key,
   input  logic [skcs_pkg::POS_W-1:0]  divisor,
   output logic                        q_valid,
   input  logic                        q_ready,
   output skcs_pkg::item_type          q_data
);
   import skcs_pkg::*;

   localparam int CW = $clog2(KEY_W + 1);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [KEY_W-1:0]  quot_ff, quot_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  div_ff, div_in;
   logic              final_ff, final_in;
   logic [POS_W:0]    shifted;
   logic              ge;
   logic              accept;

   assign req_ready = (state_ff == DV_IDLE) || ((state_ff == DV_DONE) && q_ready);
   assign accept    = req_valid && req_ready;
   assign q_valid   = (state_ff == DV_DONE);

   assign q_data.column    = WORD_W'(quot_ff);
   assign q_data.position  = rem_ff;
   assign q_data.final_key = final_ff;

   // restoring step: bring down the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, quot_ff[KEY_W-1]};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      final_in = final_ff;
      unique case (state_ff)
         DV_IDLE: ;
         DV_RUN: begin
            quot_in = {quot_ff[KEY_W-2:0], ge};
            rem_in  = ge ? POS_W'(shifted - {1'b0, div_ff}) : shifted[POS_W-1:0];
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            if (q_ready) begin
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
      if (accept) begin
         state_in = DV_RUN;
         cnt_in   = CW'(KEY_W);
         quot_in  = req_sorted_key[KEY_W-1:0];
         rem_in   = '0;
         div_in   = divisor;
         final_in = req_final_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      final_ff <= final_in;
   end

endmodule

// ----- rtl/core/skcs_queue.sv -----
module skcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  skcs_pkg::item_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output skcs_pkg::item_type out_data
);
   import skcs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- rtl/core/skcs_back.sv -----
module skcs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  skcs_pkg::item_type   q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output skcs_pkg::result_type rsp_data
);
   import skcs_pkg::*;

   logic [WORD_W-1:0] prev_col_ff, prev_col_in;
   logic [POS_W-1:0]  prev_pos_ff, prev_pos_in;
   logic [WORD_W-1:0] bc_ff, bc_in;
   logic [WORD_W-1:0] ocs_ff, ocs_in;
   logic [WORD_W-1:0] ce_ff, ce_in;
   logic [WORD_W-1:0] osf_ff, osf_in;
   logic              pend_ff, pend_in;
   logic              valid_ff, valid_in;
   result_type        result_ff, result_in;

   logic              slot_free, pop;
   logic              new_set, gap, brk;
   logic [WORD_W-1:0] bc_inc, ce_inc;

   function automatic result_type make_result(
      input logic [WORD_W-1:0] ocs,
      input logic [WORD_W-1:0] bc,
      input logic [WORD_W-1:0] ce,
      input logic [WORD_W-1:0] osf,
      input logic              set_end,
      input logic              last
   );
      result_type r;
      r.column_start     = ocs;
      r.column_length    = bc - ocs;
      r.set_closed       = set_end;
      r.set_first_column = set_end ? osf : '0;
      r.set_column_count = set_end ? (ce + WORD_W'(1) - osf) : '0;
      r.last_record      = last;
      return r;
   endfunction

   assign slot_free = !valid_ff || rsp_ready;
   assign q_ready   = slot_free && !pend_ff;
   assign pop       = q_valid && q_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = result_ff;

   assign bc_inc  = bc_ff + WORD_W'(1);
   assign ce_inc  = ce_ff + WORD_W'(1);
   assign new_set = q_data.column != prev_col_ff;
   assign gap     = {1'b0, q_data.position} != ({1'b0, prev_pos_ff} + (POS_W + 1)'(1));
   // the first key of a list never closes a column
   assign brk     = (bc_ff != '0) && (new_set || gap);

   always_comb begin
      prev_col_in = prev_col_ff;
      prev_pos_in = prev_pos_ff;
      bc_in       = bc_ff;
      ocs_in      = ocs_ff;
      ce_in       = ce_ff;
      osf_in      = osf_ff;
      pend_in     = pend_ff;
      result_in   = result_ff;
      valid_in    = valid_ff && !rsp_ready;
      if (pend_ff && slot_free) begin
         // flush the final column and set, then start a fresh list
         result_in   = make_result(ocs_ff, bc_ff, ce_ff, osf_ff, 1'b1, 1'b1);
         valid_in    = 1'b1;
         pend_in     = 1'b0;
         prev_col_in = '0;
         prev_pos_in = '0;
         bc_in       = '0;
         ocs_in      = '0;
         ce_in       = '0;
         osf_in      = '0;
      end else if (pop) begin
         prev_col_in = q_data.column;
         prev_pos_in = q_data.position;
         bc_in       = bc_inc;
         if (brk) begin
            result_in = make_result(ocs_ff, bc_ff, ce_ff, osf_ff, new_set, 1'b0);
            valid_in  = 1'b1;
            ocs_in    = bc_ff;
            ce_in     = ce_inc;
            if (new_set) begin
               osf_in = ce_inc;
            end
            pend_in = q_data.final_key;
         end else if (q_data.final_key) begin
            result_in   = make_result(ocs_ff, bc_inc, ce_ff, osf_ff, 1'b1, 1'b1);
            valid_in    = 1'b1;
            prev_col_in = '0;
            prev_pos_in = '0;
            bc_in       = '0;
            ocs_in      = '0;
            ce_in       = '0;
            osf_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_col_ff <= '0;
         prev_pos_ff <= '0;
         bc_ff       <= '0;
         ocs_ff      <= '0;
         ce_ff       <= '0;
         osf_ff      <= '0;
         pend_ff     <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         prev_col_ff <= prev_col_in;
         prev_pos_ff <= prev_pos_in;
         bc_ff       <= bc_in;
         ocs_ff      <= ocs_in;
         ce_ff       <= ce_in;
         osf_ff      <= osf_in;
         pend_ff     <= pend_in;
         valid_ff    <= valid_in;
      end
      result_ff <= result_in;
   end

`ifndef ASSERT_OFF
   a_pend_holds_output: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> valid_ff)
      else $error("final flush pending without a column result waiting");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && slot_free) |=> (bc_ff == '0 && !pend_ff && valid_ff && result_ff.last_record))
      else $error("final flush did not restart the list");

   a_no_pop_while_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !pop)
      else $error("word taken from queue while a flush is pending");
`endif

endmodule
